/* rtl/lsh_pkg.sv */
package lsh_pkg;

    // Frame constants
    localparam logic [7:0] HDLC_FLAG  = 8'h7E;
    localparam int         TIMER_BITS = 16;
    localparam int         FRAME_LEN  = 5;
    localparam logic [2:0] FRAME_LAST = 3'(FRAME_LEN - 1);

    // Input opcodes
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_RX    = 2'd1,
        OP_TICK  = 2'd2
    } opcode_t;

    // Link phase, also the reported status
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_CONN = 2'd2,
        PH_FAIL = 2'd3
    } phase_t;

    // UA recognizer states
    typedef enum logic [2:0] {
        RS_START = 3'd0,
        RS_FLAG  = 3'd1,
        RS_ADDR  = 3'd2,
        RS_CTRL  = 3'd3,
        RS_BCC   = 3'd4
    } rx_state_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_TIMEOUT  = 3'd0,
        REG_MAX_ATT  = 3'd1,
        REG_ADDRESS  = 3'd2,
        REG_SET_CTRL = 3'd3,
        REG_UA_CTRL  = 3'd4
    } reg_idx_t;

    localparam int ADDR_BITS = 5;

    // Configuration seen by the core
    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [3:0]  max_attempts;
        logic [7:0]  address_byte;
        logic [7:0]  set_control;
        logic [7:0]  ua_control;
    } cfg_t;

endpackage

/* rtl/link_setup_handshake.sv */
// Link setup handshake, initiator side (SET / UA exchange).
// Input channel (s_): one word per opcode: start, received byte or tick.
// Result channel (m_): words of tx_valid, tx_byte, status and last.
// A start, or a timeout that retransmits, produces the five SET frame words
// (flag, address, control, address ^ control, flag); every other word
// produces one status word with tx_valid low. last marks the final word.
// The first result word is shown the cycle after the input is accepted.
// Single-result words are taken one per cycle while the receiver does not
// stall; a SET frame holds the input until its final byte is being taken,
// as the one-word result register steps through the frame bytes.
// A stalled receiver holds the result register; the input side keeps
// accepting as long as the result register is free or being drained by its
// final word in that cycle.
// Reset (aresetn low, synchronous) returns the link to idle, clears the
// timer and attempt counter, restarts the UA recognizer, empties the result
// register and loads the default configuration: timeout 3, attempts 3,
// address 3, SET control 3, UA control 7.
// Configuration is an APB-style port, register i at byte address 4*i.
module link_setup_handshake (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_opcode,
    input  logic [7:0]                    s_rx_byte,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_tx_valid,
    output logic [7:0]                    m_tx_byte,
    output logic [1:0]                    m_status,
    output logic                          m_last,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsh_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import lsh_pkg::*;

    cfg_t cfg;

    lsh_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Link state
    rx_state_t             rs_reg, rs_next;
    phase_t                ph_reg, ph_next;
    logic [TIMER_BITS-1:0] tick_reg, tick_next;
    logic [3:0]            att_reg, att_next;
    logic                  emit_set;

    // Result register
    logic       out_valid_reg;
    logic       out_set_reg;
    logic [2:0] out_idx_reg;
    phase_t     out_status_reg;

    logic       s_acc, m_acc, out_done;
    opcode_t    op;

    localparam logic [TIMER_BITS-1:0] TICK_MAX = {TIMER_BITS{1'b1}};

    logic [TIMER_BITS-1:0] limit;
    logic [TIMER_BITS-1:0] tick_inc;
    logic [3:0]            att_inc;
    logic [7:0]            ua_bcc, set_bcc;

    assign op       = opcode_t'(s_opcode);
    assign ua_bcc   = cfg.address_byte ^ cfg.ua_control;
    assign set_bcc  = cfg.address_byte ^ cfg.set_control;
    assign out_done = !out_set_reg || (out_idx_reg == FRAME_LAST);
    assign m_acc    = out_valid_reg && m_ready;
    assign s_ready  = !out_valid_reg || (m_ready && out_done);
    assign s_acc    = s_valid && s_ready;

    // Effective timeout: zero counts as one, clamp to the timer range
    always_comb begin
        if (TIMER_BITS >= 16) begin
            limit = TIMER_BITS'(cfg.timeout_ticks);
        end else if (cfg.timeout_ticks > 16'(TICK_MAX)) begin
            limit = TICK_MAX;
        end else begin
            limit = TIMER_BITS'(cfg.timeout_ticks);
        end
        if (limit == '0) begin
            limit = TIMER_BITS'(1);
        end
    end

    assign tick_inc = (tick_reg < TICK_MAX) ? tick_reg + TIMER_BITS'(1) : tick_reg;
    assign att_inc  = att_reg + 4'd1;

    // Next link state for the word at the input
    always_comb begin
        rs_next   = rs_reg;
        ph_next   = ph_reg;
        tick_next = tick_reg;
        att_next  = att_reg;
        emit_set  = 1'b0;
        case (op)
            OP_START: begin
                rs_next   = RS_START;
                ph_next   = PH_WAIT;
                tick_next = '0;
                att_next  = 4'd0;
                emit_set  = 1'b1;
            end
            OP_RX: begin
                if (ph_reg == PH_WAIT) begin
                    unique case (rs_reg)
                        RS_START: begin
                            if (s_rx_byte == HDLC_FLAG) rs_next = RS_FLAG;
                        end
                        RS_FLAG: begin
                            if (s_rx_byte != HDLC_FLAG) begin
                                rs_next = (s_rx_byte == cfg.address_byte) ?
                                          RS_ADDR : RS_START;
                            end
                        end
                        RS_ADDR: begin
                            if (s_rx_byte == cfg.ua_control) rs_next = RS_CTRL;
                            else if (s_rx_byte == HDLC_FLAG) rs_next = RS_FLAG;
                            else rs_next = RS_START;
                        end
                        RS_CTRL: begin
                            if (s_rx_byte == ua_bcc) rs_next = RS_BCC;
                            else if (s_rx_byte == HDLC_FLAG) rs_next = RS_FLAG;
                            else rs_next = RS_START;
                        end
                        RS_BCC: begin
                            if (s_rx_byte == HDLC_FLAG) ph_next = PH_CONN;
                            rs_next = RS_START;
                        end
                        default: rs_next = RS_START;
                    endcase
                end
            end
            OP_TICK: begin
                if (ph_reg == PH_WAIT) begin
                    tick_next = tick_inc;
                    if (tick_inc >= limit) begin
                        tick_next = '0;
                        att_next  = att_inc;
                        if (att_inc >= cfg.max_attempts) begin
                            ph_next = PH_FAIL;
                        end else begin
                            rs_next  = RS_START;
                            emit_set = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Link state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rs_reg   <= RS_START;
            ph_reg   <= PH_IDLE;
            tick_reg <= '0;
            att_reg  <= 4'd0;
        end else if (s_acc) begin
            rs_reg   <= rs_next;
            ph_reg   <= ph_next;
            tick_reg <= tick_next;
            att_reg  <= att_next;
        end
    end

    // Result register: load on accept, step through the frame on drain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_set_reg   <= 1'b0;
            out_idx_reg   <= 3'd0;
        end else if (s_acc) begin
            out_valid_reg <= 1'b1;
            out_set_reg   <= emit_set;
            out_idx_reg   <= 3'd0;
        end else if (m_acc) begin
            if (out_done) begin
                out_valid_reg <= 1'b0;
            end else begin
                out_idx_reg <= out_idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            out_status_reg <= ph_next;
        end
    end

    // Frame byte select
    always_comb begin
        m_tx_byte = 8'd0;
        if (out_set_reg) begin
            case (out_idx_reg)
                3'd1:    m_tx_byte = cfg.address_byte;
                3'd2:    m_tx_byte = cfg.set_control;
                3'd3:    m_tx_byte = set_bcc;
                default: m_tx_byte = HDLC_FLAG;
            endcase
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_tx_valid = out_set_reg;
    assign m_status   = out_status_reg;
    assign m_last     = out_done;

endmodule

/* rtl/lsh_apb_regs.sv */
module lsh_apb_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsh_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output lsh_pkg::cfg_t                 cfg
);
    import lsh_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ticks <= 16'd3;
            cfg_reg.max_attempts  <= 4'd3;
            cfg_reg.address_byte  <= 8'd3;
            cfg_reg.set_control   <= 8'd3;
            cfg_reg.ua_control    <= 8'd7;
        end else if (wr_en) begin
            unique case (idx)
                REG_TIMEOUT:  cfg_reg.timeout_ticks <= pwdata[15:0];
                REG_MAX_ATT:  cfg_reg.max_attempts  <= pwdata[3:0];
                REG_ADDRESS:  cfg_reg.address_byte  <= pwdata[7:0];
                REG_SET_CTRL: cfg_reg.set_control   <= pwdata[7:0];
                REG_UA_CTRL:  cfg_reg.ua_control    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = 32'd0;
        unique case (idx)
            REG_TIMEOUT:  prdata = {16'd0, cfg_reg.timeout_ticks};
            REG_MAX_ATT:  prdata = {28'd0, cfg_reg.max_attempts};
            REG_ADDRESS:  prdata = {24'd0, cfg_reg.address_byte};
            REG_SET_CTRL: prdata = {24'd0, cfg_reg.set_control};
            REG_UA_CTRL:  prdata = {24'd0, cfg_reg.ua_control};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

/* rtl/lsh_checker.sv */
module lsh_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_opcode,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_tx_valid,
    input logic [7:0] m_tx_byte,
    input logic [1:0] m_status,
    input logic       m_last
);
    import lsh_pkg::*;

    // A stalled result word stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // Status words carry no byte and end their group
    a_status_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tx_valid |-> m_last && (m_tx_byte == 8'd0))
        else $error("status word malformed");

    // A start opens a SET frame with a flag, waiting for UA
    a_start_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_opcode == OP_START) |=>
            m_valid && m_tx_valid && (m_tx_byte == HDLC_FLAG) && !m_last &&
            (m_status == PH_WAIT))
        else $error("start did not open a SET frame");

    // Frame continues after a non-final frame byte is taken
    a_frame_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_tx_valid && !m_last |=> m_valid && m_tx_valid)
        else $error("SET frame cut short");

    // No new input word while a frame still has bytes to send
    a_frame_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tx_valid && !m_last |-> !s_ready)
        else $error("input accepted mid-frame");

endmodule

bind link_setup_handshake lsh_checker u_lsh_checker (.*);

/* bench/link_setup_handshake_tb.sv */
module link_setup_handshake_tb;
    import lsh_pkg::*;

    // Opcode that the block must ignore apart from reporting status
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One result word as the block shows it
    typedef struct {
        logic       tx_valid;
        logic [7:0] tx_byte;
        phase_t     status;
        logic       last;
    } tx_word_t;

    // Tracks link state and holds the result words still to come
    class link_tracker;
        logic [15:0] timeout_ticks;
        logic [3:0]  max_attempts;
        logic [7:0]  address_byte;
        logic [7:0]  set_control;
        logic [7:0]  ua_control;
        rx_state_t   ua_state;
        phase_t      phase;
        logic [15:0] tick_count;
        logic [3:0]  attempts;
        tx_word_t    awaited_words[$];
        int          errors;

        function new();
            timeout_ticks = 16'd3;
            max_attempts  = 4'd3;
            address_byte  = 8'd3;
            set_control   = 8'd3;
            ua_control    = 8'd7;
            ua_state      = RS_START;
            phase         = PH_IDLE;
            tick_count    = '0;
            attempts      = '0;
            errors        = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_TIMEOUT:  timeout_ticks = value[15:0];
                REG_MAX_ATT:  max_attempts  = value[3:0];
                REG_ADDRESS:  address_byte  = value[7:0];
                REG_SET_CTRL: set_control   = value[7:0];
                REG_UA_CTRL:  ua_control    = value[7:0];
                default: ;
            endcase
        endfunction

        // SET frame: flag, address, control, BCC, flag
        function void queue_set_frame();
            logic [7:0] frame_bytes [FRAME_LEN];
            frame_bytes = '{HDLC_FLAG, address_byte, set_control,
                            address_byte ^ set_control, HDLC_FLAG};
            for (int k = 0; k < FRAME_LEN; k++) begin
                awaited_words.push_back('{1'b1, frame_bytes[k], phase,
                                          (k == FRAME_LEN - 1)});
            end
        endfunction

        function void note_word(logic [1:0] op, logic [7:0] data);
            logic [15:0] limit;
            limit = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
            case (op)
                OP_START: begin
                    // restarts from any phase
                    ua_state   = RS_START;
                    tick_count = '0;
                    attempts   = '0;
                    phase      = PH_WAIT;
                    queue_set_frame();
                    return;
                end
                OP_RX: if (phase == PH_WAIT) begin
                    // UA recognizer
                    case (ua_state)
                        RS_START: if (data == HDLC_FLAG) ua_state = RS_FLAG;
                        RS_FLAG: begin
                            if (data != HDLC_FLAG) begin
                                if (data == address_byte) ua_state = RS_ADDR;
                                else ua_state = RS_START;
                            end
                        end
                        RS_ADDR: begin
                            if (data == ua_control) ua_state = RS_CTRL;
                            else if (data == HDLC_FLAG) ua_state = RS_FLAG;
                            else ua_state = RS_START;
                        end
                        RS_CTRL: begin
                            if (data == (address_byte ^ ua_control)) ua_state = RS_BCC;
                            else if (data == HDLC_FLAG) ua_state = RS_FLAG;
                            else ua_state = RS_START;
                        end
                        RS_BCC: begin
                            if (data == HDLC_FLAG) phase = PH_CONN;
                            ua_state = RS_START;
                        end
                        default: ua_state = RS_START;
                    endcase
                end
                OP_TICK: if (phase == PH_WAIT) begin
                    // timer saturates; expiry resends or gives up
                    if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
                    if (tick_count >= limit) begin
                        tick_count = '0;
                        attempts   = attempts + 4'd1;
                        if (attempts >= max_attempts) begin
                            phase = PH_FAIL;
                        end else begin
                            ua_state = RS_START;
                            queue_set_frame();
                            return;
                        end
                    end
                end
                default: ;
            endcase
            awaited_words.push_back('{1'b0, 8'h00, phase, 1'b1});
        endfunction

        function void check_word(logic tx_valid, logic [7:0] tx_byte,
                                 logic [1:0] status, logic last);
            tx_word_t want;
            if (awaited_words.size() == 0) begin
                $error("unexpected result word: tx_valid %0d tx_byte %0h status %0d last %0d",
                       tx_valid, tx_byte, status, last);
                errors++;
                return;
            end
            want = awaited_words.pop_front();
            if (tx_valid !== want.tx_valid) begin
                $error("tx_valid: expected %0d, actual %0d", want.tx_valid, tx_valid);
                errors++;
            end
            if (tx_byte !== want.tx_byte) begin
                $error("tx_byte: expected %0h, actual %0h", want.tx_byte, tx_byte);
                errors++;
            end
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_opcode  = OP_START;
    logic [7:0]           s_rx_byte = 8'h00;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 m_tx_valid;
    logic [7:0]           m_tx_byte;
    logic [1:0]           m_status;
    logic                 m_last;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [ADDR_BITS-1:0] paddr     = '0;
    logic [31:0]          pwdata    = '0;
    logic [31:0]          prdata;
    logic                 pready;

    link_tracker link;
    int          words_sent = 0;
    int          rx_hold    = 0;
    bit          tx_calm    = 1'b0;
    bit          rx_calm    = 1'b0;

    always #1 aclk = ~aclk;

    link_setup_handshake i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_rx_byte  (s_rx_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_tx_valid (m_tx_valid),
        .m_tx_byte  (m_tx_byte),
        .m_status   (m_status),
        .m_last     (m_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    // Result side: check each accepted word, then stall for a drawn number of cycles
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            link.check_word(m_tx_valid, m_tx_byte, m_status, m_last);
            rx_hold = draw_wait(rx_calm);
        end else if (rx_hold != 0) begin
            rx_hold = rx_hold - 1;
        end
    end

    always @(negedge aclk) begin
        m_ready <= (rx_hold == 0);
    end

    // Input side: valid stays high from one word to the next when no gap is drawn
    task automatic send_word(input logic [1:0] op, input logic [7:0] data);
        int gap;
        gap = draw_wait(tx_calm);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_rx_byte <= data;
        do @(posedge aclk); while (!s_ready);
        link.note_word(op, data);
        words_sent++;
    endtask

    // Let every awaited word drain before touching the registers
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (link.awaited_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Register write: setup cycle, then access cycle
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        link.set_reg(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] timeout, input logic [3:0] attempts,
                             input logic [7:0] address, input logic [7:0] set_ctrl,
                             input logic [7:0] ua_ctrl);
        settle();
        write_reg(REG_TIMEOUT,  {16'd0, timeout});
        write_reg(REG_MAX_ATT,  {28'd0, attempts});
        write_reg(REG_ADDRESS,  {24'd0, address});
        write_reg(REG_SET_CTRL, {24'd0, set_ctrl});
        write_reg(REG_UA_CTRL,  {24'd0, ua_ctrl});
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_word(OP_TICK, 8'($urandom));
            1: send_word(OP_UNUSED, 8'($urandom));
            default: send_word(OP_RX, 8'($urandom));
        endcase
    endtask

    // One attempt: start, maybe noise, a UA frame (sometimes damaged), then maybe ticks and noise
    task automatic send_episode();
        logic [7:0] frame [$];
        int         pos;
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        send_word(OP_START, 8'($urandom));
        repeat ($urandom_range(0, 2)) send_noise();
        repeat ($urandom_range(0, 2)) frame.push_back(HDLC_FLAG);
        frame.push_back(HDLC_FLAG);
        frame.push_back(link.address_byte);
        frame.push_back(link.ua_control);
        frame.push_back(link.address_byte ^ link.ua_control);
        frame.push_back(HDLC_FLAG);
        if ($urandom_range(0, 3) == 0) begin
            pos = $urandom_range(0, frame.size() - 1);
            frame[pos] = ($urandom_range(0, 1) == 1) ? HDLC_FLAG : 8'($urandom);
        end
        foreach (frame[k]) begin
            if ($urandom_range(0, 9) == 0) send_word(OP_TICK, 8'($urandom));
            send_word(OP_RX, frame[k]);
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 8)) send_word(OP_TICK, 8'($urandom));
        end
        repeat ($urandom_range(0, 3)) send_noise();
    endtask

    // Run limit, far above the slowest legal run
    initial begin
        #800000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int phase_start;
        link = new();
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: idle inputs, clean UA with a repeated flag, resync and mismatch
        send_word(OP_UNUSED, 8'h00);
        send_word(OP_RX, 8'hFF);
        send_word(OP_TICK, 8'h00);
        send_word(OP_START, 8'hFF);
        send_word(OP_RX, HDLC_FLAG);
        send_word(OP_RX, HDLC_FLAG);
        send_word(OP_RX, 8'h03);
        send_word(OP_RX, 8'h07);
        send_word(OP_RX, 8'h04);
        send_word(OP_RX, HDLC_FLAG);
        send_word(OP_TICK, 8'h00);
        send_word(OP_UNUSED, 8'hFF);
        send_word(OP_START, 8'h00);
        send_word(OP_RX, HDLC_FLAG);
        send_word(OP_RX, 8'h03);
        send_word(OP_RX, HDLC_FLAG);
        send_word(OP_RX, 8'h03);
        send_word(OP_RX, 8'h07);
        send_word(OP_RX, HDLC_FLAG);
        send_word(OP_RX, 8'h00);

        // Zero timeout counts as one tick; start while waiting; resend then fail
        configure(16'd0, 4'd2, 8'hFF, 8'h00, HDLC_FLAG);
        send_word(OP_START, 8'h5A);
        send_word(OP_TICK, 8'hA5);
        send_word(OP_TICK, 8'h00);
        send_word(OP_RX, HDLC_FLAG);
        send_word(OP_TICK, 8'hFF);

        // Zero attempts: first timeout fails
        configure(16'd1, 4'd0, 8'h00, 8'hFF, 8'h00);
        send_word(OP_START, 8'h00);
        send_word(OP_TICK, 8'h00);

        // Random phases, extreme settings first
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: configure(16'd1, 4'd1, 8'h00, 8'h00, 8'h00);
                1: configure(16'hFFFF, 4'd15, 8'hFF, 8'hFF, 8'hFF);
                2: configure(16'd2, 4'd15, HDLC_FLAG, 8'h81, HDLC_FLAG);
                3: configure(16'd0, 4'd0, 8'($urandom), 8'($urandom), 8'($urandom));
                default: configure(16'($urandom_range(1, 6)), 4'($urandom_range(0, 15)),
                                   8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            phase_start = words_sent;
            while (words_sent - phase_start < 42) send_episode();
        end

        settle();
        repeat (8) @(posedge aclk);
        if (link.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* link_setup_handshake.f */
rtl/lsh_pkg.sv
rtl/lsh_apb_regs.sv
rtl/link_setup_handshake.sv
rtl/lsh_checker.sv
bench/link_setup_handshake_tb.sv
